FILE: src/xbd_pkg.sv
// ----------------------------------------------------------------------------
// XTEA block decrypt package
// Shared word types, register indexes and the round mixing function.
// ----------------------------------------------------------------------------
package xbd_pkg;

    // Round constant of the cipher
    localparam logic [31:0] XBD_DELTA       = 32'h9E3779B9;
    // Register index width and reset round count
    localparam int          XBD_CFG_IW      = 3;
    localparam logic [5:0]  XBD_ROUND_RESET = 6'd32;

    // Configuration register indexes
    typedef enum logic [XBD_CFG_IW-1:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_ROUNDS = 3'd4
    } t_cfg_index;

    // Four key words, indexed by the two selector bits of the sum
    typedef logic [3:0][31:0] t_key_set;

    // Input word: one ciphertext block
    typedef struct packed {
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
    } t_in_word;

    // Output word: one plaintext block
    typedef struct packed {
        logic [31:0] plain_first;
        logic [31:0] plain_second;
    } t_out_word;

    // Working state carried down the pipeline
    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
    } t_lane;

    // Shift-xor-add mixing of one word
    function automatic logic [31:0] mix_word(input logic [31:0] w);
        mix_word = ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

FILE: src/xbd_cfg.sv
// ----------------------------------------------------------------------------
// XTEA block decrypt configuration registers
// Holds the four key words and the raw round count.
// ----------------------------------------------------------------------------
module xbd_cfg
    import xbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [XBD_CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output t_key_set              o_key,
    output logic [5:0]            o_round_count
);

    t_key_set   r_key;
    logic [5:0] r_round_count;

    // Write one register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key         <= '0;
            r_round_count <= XBD_ROUND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY0:   r_key[0]      <= i_cfg_data;
                CFG_KEY1:   r_key[1]      <= i_cfg_data;
                CFG_KEY2:   r_key[2]      <= i_cfg_data;
                CFG_KEY3:   r_key[3]      <= i_cfg_data;
                CFG_ROUNDS: r_round_count <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign o_key         = r_key;
    assign o_round_count = r_round_count;

endmodule

FILE: src/xbd_half_v1.sv
// ----------------------------------------------------------------------------
// XTEA block decrypt first half round
// Subtracts from the second word, keyed by sum bits 12..11, and steps the
// sum down by delta. One register stage with its own flow control.
// ----------------------------------------------------------------------------
module xbd_half_v1
    import xbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_active,
    input  t_key_set i_key,
    input  logic     i_valid,
    input  t_lane    i_lane,
    output logic     o_ready,
    output logic     o_valid,
    output t_lane    o_lane,
    input  logic     i_ready
);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    logic  w_ready;

    // Half-round arithmetic; idle rounds pass through
    always_comb begin
        n_lane = i_lane;
        if (i_active) begin
            n_lane.v1  = i_lane.v1 - (mix_word(i_lane.v0)
                         ^ (i_lane.sum + i_key[i_lane.sum[12:11]]));
            n_lane.sum = i_lane.sum - XBD_DELTA;
        end
    end

    assign w_ready = !r_valid || i_ready;

    // Advance when the next stage takes the word or this one is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: src/xbd_half_v0.sv
// ----------------------------------------------------------------------------
// XTEA block decrypt second half round
// Subtracts from the first word, keyed by sum bits 1..0 of the lowered sum.
// One register stage with its own flow control.
// ----------------------------------------------------------------------------
module xbd_half_v0
    import xbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_active,
    input  t_key_set i_key,
    input  logic     i_valid,
    input  t_lane    i_lane,
    output logic     o_ready,
    output logic     o_valid,
    output t_lane    o_lane,
    input  logic     i_ready
);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    logic  w_ready;

    // Half-round arithmetic; idle rounds pass through
    always_comb begin
        n_lane = i_lane;
        if (i_active) begin
            n_lane.v0 = i_lane.v0 - (mix_word(i_lane.v1)
                        ^ (i_lane.sum + i_key[i_lane.sum[1:0]]));
        end
    end

    assign w_ready = !r_valid || i_ready;

    // Advance when the next stage takes the word or this one is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: src/xtea_block_decrypt.sv
// Pipeline: one entry register plus one register per half round.
// Throughput: one word per cycle while the output is not stalled; every
// half round has its own stage and each stage advances on its own, so
// bubbles close up under output stall.
// Reset: synchronous, active low; clears all valid bits, key words to zero
// and the round count to 32.
// ----------------------------------------------------------------------------
// XTEA block decrypt
// Unrolled 64-bit block XTEA decryption with a 128-bit key.
// ----------------------------------------------------------------------------
module xtea_block_decrypt
    import xbd_pkg::*;
#(
    parameter int MAX_ROUNDS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [XBD_CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data
);

    localparam int NSTAGE = 2 * MAX_ROUNDS;
    localparam int RW     = $clog2(MAX_ROUNDS + 1);

    t_key_set       w_key;
    logic [5:0]     w_round_count;
    logic [RW-1:0]  w_rounds;

    logic           r_ent_valid;
    t_lane          r_ent_lane;
    t_lane          n_ent_lane;
    logic           w_ent_ready;

    logic           w_valid [0:NSTAGE];
    t_lane          w_lane  [0:NSTAGE];
    logic           w_take  [0:NSTAGE];

    xbd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_key         (w_key),
        .o_round_count (w_round_count)
    );

    // Clamp the round count to the built depth
    always_comb begin
        if ({1'b0, w_round_count} > 7'(MAX_ROUNDS)) begin
            w_rounds = RW'(MAX_ROUNDS);
        end else begin
            w_rounds = RW'(w_round_count);
        end
    end

    // Entry stage: load the block and the starting sum
    always_comb begin
        n_ent_lane.v0  = i_in_data.cipher_first;
        n_ent_lane.v1  = i_in_data.cipher_second;
        n_ent_lane.sum = XBD_DELTA * 32'(w_rounds);
    end

    assign w_ent_ready = !r_ent_valid || w_take[0];
    assign o_in_stall  = !w_ent_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
        end else if (w_ent_ready) begin
            r_ent_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_ready && i_in_valid) begin
            r_ent_lane <= n_ent_lane;
        end
    end

    assign w_valid[0] = r_ent_valid;
    assign w_lane[0]  = r_ent_lane;

    // Half-round stages; rounds past the count pass the word through
    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        logic w_active;
        assign w_active = (w_rounds > RW'(s / 2));
        if (s % 2 == 0) begin : g_v1
            xbd_half_v1 u_half (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_active (w_active),
                .i_key    (w_key),
                .i_valid  (w_valid[s]),
                .i_lane   (w_lane[s]),
                .o_ready  (w_take[s]),
                .o_valid  (w_valid[s+1]),
                .o_lane   (w_lane[s+1]),
                .i_ready  (w_take[s+1])
            );
        end else begin : g_v0
            xbd_half_v0 u_half (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_active (w_active),
                .i_key    (w_key),
                .i_valid  (w_valid[s]),
                .i_lane   (w_lane[s]),
                .o_ready  (w_take[s]),
                .o_valid  (w_valid[s+1]),
                .o_lane   (w_lane[s+1]),
                .i_ready  (w_take[s+1])
            );
        end
    end

    // Last stage register is the output register
    assign w_take[NSTAGE]          = !i_out_stall;
    assign o_out_valid             = w_valid[NSTAGE];
    assign o_out_data.plain_first  = w_lane[NSTAGE].v0;
    assign o_out_data.plain_second = w_lane[NSTAGE].v1;

`ifndef SYNTHESIS
    // Accepted input word lands in the entry register
    a_entry_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_ent_valid)
        else $error("accepted word missing from entry stage");

    // Input stalls only while the entry stage holds a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_ent_valid)
        else $error("input stalled with empty entry stage");

    // Empty output register never holds back the last half round
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> w_take[NSTAGE-1])
        else $error("last stage blocked by empty output");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// XTEA block decrypt testbench
// Sends ciphertext blocks through the round pipeline under several key and
// round settings. Every decrypted word is checked in order against an
// in-bench decipher model, or against a value typed into the table. Both
// sides idle at random, and the output holds off long enough to fill the
// pipeline.
// ----------------------------------------------------------------------------
module tb_top
    import xbd_pkg::*;
();

    localparam int ROUND_LIMIT    = 32;
    localparam int CFG_SLOTS      = 1 << XBD_CFG_IW;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * ROUND_LIMIT + 20;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int VECTOR_COUNT   = 16;

    typedef enum logic [1:0] {
        KEYS_ZERO,
        KEYS_ONES,
        KEYS_MIXED
    } t_key_mode;

    // One directed row: the settings it needs, the block, and an optional
    // expected word read straight off the cipher definition
    typedef struct packed {
        logic [5:0] rounds;
        t_key_mode  key_mode;
        t_in_word   blk;
        logic       typed;
        t_out_word  plain;
    } t_vector_row;

    localparam t_key_set KEY_PATTERN = {32'h76543210, 32'hFEDCBA98,
                                        32'h89ABCDEF, 32'h01234567};
    localparam t_cfg_index KEY_SLOT [4] = '{CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3};

    localparam t_vector_row VECTORS [VECTOR_COUNT] = '{
        // reset settings: zero key, full round count
        '{6'd32, KEYS_ZERO,  '{32'h00000000, 32'h00000000}, 1'b0, '{32'h0, 32'h0}},
        '{6'd32, KEYS_ZERO,  '{32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '{32'h0, 32'h0}},
        '{6'd32, KEYS_ZERO,  '{32'hDEE9D4D8, 32'hF7131ED9}, 1'b0, '{32'h0, 32'h0}},
        '{6'd32, KEYS_ZERO,  '{32'h00000000, 32'hFFFFFFFF}, 1'b0, '{32'h0, 32'h0}},
        // zero rounds: the block comes back unchanged
        '{6'd0,  KEYS_ZERO,  '{32'h00000000, 32'h00000000}, 1'b1,
                             '{32'h00000000, 32'h00000000}},
        '{6'd0,  KEYS_ZERO,  '{32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
                             '{32'hFFFFFFFF, 32'hFFFFFFFF}},
        '{6'd0,  KEYS_ZERO,  '{32'h12345678, 32'h9ABCDEF0}, 1'b1,
                             '{32'h12345678, 32'h9ABCDEF0}},
        '{6'd0,  KEYS_ONES,  '{32'hA5A5A5A5, 32'h5A5A5A5A}, 1'b1,
                             '{32'hA5A5A5A5, 32'h5A5A5A5A}},
        // single round, all-ones key
        '{6'd1,  KEYS_ONES,  '{32'hFFFFFFFF, 32'h00000000}, 1'b0, '{32'h0, 32'h0}},
        '{6'd1,  KEYS_ONES,  '{32'h80000001, 32'h7FFFFFFE}, 1'b0, '{32'h0, 32'h0}},
        // mixed key: counts above the built maximum saturate, then lower counts
        '{6'd63, KEYS_MIXED, '{32'h01234567, 32'h89ABCDEF}, 1'b0, '{32'h0, 32'h0}},
        '{6'd63, KEYS_MIXED, '{32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '{32'h0, 32'h0}},
        '{6'd33, KEYS_MIXED, '{32'h01234567, 32'h89ABCDEF}, 1'b0, '{32'h0, 32'h0}},
        '{6'd32, KEYS_MIXED, '{32'h01234567, 32'h89ABCDEF}, 1'b0, '{32'h0, 32'h0}},
        '{6'd31, KEYS_MIXED, '{32'hC3C3C3C3, 32'h3C3C3C3C}, 1'b0, '{32'h0, 32'h0}},
        '{6'd2,  KEYS_MIXED, '{32'h00000001, 32'h80000000}, 1'b0, '{32'h0, 32'h0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [XBD_CFG_IW-1:0] i_cfg_index;
    logic [31:0]           i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_data;

    // Shadow copy of the configuration, updated on each register write
    t_key_set   key_bank;
    logic [5:0] round_reg;

    // Decrypted words still owed by the block, oldest first
    t_out_word  pending_plain [$];

    bit steady_run;
    bit hold_armed;
    int fail_count;
    int idle_cycles;

    xtea_block_decrypt #(
        .MAX_ROUNDS (ROUND_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Shift-xor-add spread of one word
    function automatic logic [31:0] fold_word(input logic [31:0] w);
        logic [31:0] spread;
        spread = (w << 4) ^ (w >> 5);
        return spread + w;
    endfunction

    // Run the decryption rounds under the current shadow settings
    function automatic t_out_word decipher_block(input t_in_word blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] acc;
        int          passes;
        t_out_word   res;
        v0     = blk.cipher_first;
        v1     = blk.cipher_second;
        passes = (round_reg > ROUND_LIMIT) ? ROUND_LIMIT : int'(round_reg);
        acc    = '0;
        repeat (passes) acc = acc + XBD_DELTA;
        for (int r = 0; r < passes; r++) begin
            v1  = v1 - (fold_word(v0) ^ (acc + key_bank[acc[12:11]]));
            acc = acc - XBD_DELTA;
            v0  = v0 - (fold_word(v1) ^ (acc + key_bank[acc[1:0]]));
        end
        res.plain_first  = v0;
        res.plain_second = v1;
        return res;
    endfunction

    function automatic t_key_set keys_for(input t_key_mode mode);
        case (mode)
            KEYS_ZERO: return '0;
            KEYS_ONES: return '1;
            default:   return KEY_PATTERN;
        endcase
    endfunction

    // Bias toward the extremes now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h00000000;
            1:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drive one register write; the enable stays high for the caller
    task automatic write_reg(input logic [XBD_CFG_IW-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx <= CFG_KEY3) begin
            key_bank[idx[1:0]] = val;
        end else if (idx == CFG_ROUNDS) begin
            round_reg = val[5:0];
        end
    endtask

    // Load all registers; junk goes into the upper round bits and the
    // unused indexes, neither of which may take effect
    task automatic apply_settings(input t_key_set keys, input logic [5:0] rounds);
        logic [31:0] junk;
        junk = $urandom;
        for (int k = 0; k < 4; k++) begin
            write_reg(KEY_SLOT[k], keys[k]);
        end
        write_reg(CFG_ROUNDS, {junk[31:6], rounds});
        for (int s = int'(CFG_ROUNDS) + 1; s < CFG_SLOTS; s++) begin
            write_reg(XBD_CFG_IW'(s), $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every owed word has come out
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending_plain.size() != 0) @(posedge i_clk);
    endtask

    // Offer one block and log what it must decrypt to once accepted
    task automatic offer_block(input t_in_word blk, input logic typed,
                               input t_out_word plain);
        if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_plain.push_back(typed ? plain : decipher_block(blk));
    endtask

    // Receiver: random stall, or a long hold-off when armed
    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
            end else begin
                i_out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare each decrypted word with the oldest one owed
    always @(posedge i_clk) begin : check_plain
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_plain.size() == 0) begin
                $error("unexpected word: plain_first=%h plain_second=%h",
                       o_out_data.plain_first, o_out_data.plain_second);
                fail_count++;
            end else begin
                want = pending_plain.pop_front();
                if (o_out_data.plain_first !== want.plain_first) begin
                    $error("plain_first: expected %h, actual %h",
                           want.plain_first, o_out_data.plain_first);
                    fail_count++;
                end
                if (o_out_data.plain_second !== want.plain_second) begin
                    $error("plain_second: expected %h, actual %h",
                           want.plain_second, o_out_data.plain_second);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no traffic on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_vector_row row;
        t_key_mode   key_mode_now;
        t_key_set    keys;
        logic [5:0]  rounds;
        t_in_word    blk;
        t_out_word   none;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        steady_run  = 1'b0;
        hold_armed  = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        none        = '0;
        key_bank    = '0;
        round_reg   = XBD_ROUND_RESET;
        key_mode_now = KEYS_ZERO;

        // Hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; settings change only once the pipeline is empty
        for (int v = 0; v < VECTOR_COUNT; v++) begin
            row = VECTORS[v];
            if (row.rounds != round_reg || row.key_mode != key_mode_now) begin
                finish_phase();
                apply_settings(keys_for(row.key_mode), row.rounds);
                key_mode_now = row.key_mode;
            end
            offer_block(row.blk, row.typed, row.plain);
        end

        // Random phases, each under its own settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            finish_phase();
            case (p)
                0:       rounds = 6'd32;
                1:       rounds = 6'd0;
                2:       rounds = 6'd63;
                4:       rounds = 6'd1;
                6:       rounds = 6'd33;
                7:       rounds = 6'd32;
                default: rounds = 6'($urandom_range(63));
            endcase
            if (p == 2) begin
                keys = '1;
            end else if (p == 4) begin
                keys = '0;
            end else begin
                keys = {$urandom, $urandom, $urandom, $urandom};
            end
            apply_settings(keys, rounds);
            steady_run = (p == 0);
            // Long output hold-off while the sender keeps pushing
            if (p == 3) begin
                hold_armed = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Sender pause until the pipeline has emptied
                if (p == 6 && i == PHASE_ITEMS / 2) begin
                    finish_phase();
                end
                blk.cipher_first  = pick_word();
                blk.cipher_second = pick_word();
                offer_block(blk, 1'b0, none);
            end
        end

        finish_phase();
        steady_run = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
src/xbd_pkg.sv
src/xbd_cfg.sv
src/xbd_half_v1.sv
src/xbd_half_v0.sv
src/xtea_block_decrypt.sv
verif/tb_top.sv
